### rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Both macros sample on clk_i and are
// disabled while rst_ni is low. In synthesis builds they expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

### rtl/msa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package msa_pkg;

  // Row geometry.
  localparam int MAX_SEATS  = 1024;
  localparam int SEAT_W     = $clog2(MAX_SEATS);
  localparam int CNT_W      = $clog2(MAX_SEATS + 1);

  // Field widths of the channel words and the register.
  localparam int MODE_W     = 1;
  localparam int POS_W      = 10;
  localparam int STAT_W     = 2;
  localparam int CFG_W      = 11;
  localparam int SEAT_RESET = 1024;

  typedef enum logic [MODE_W-1:0] {
    MODE_TAKE    = 1'b0,
    MODE_RELEASE = 1'b1
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_SEATED   = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_RELEASED = 2'd2,
    STAT_IGNORED  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_TAIL,
    S_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_en;
    logic accept;
    logic scan_rd;
    logic finish;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic scan_last;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

### rtl/msa_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one word per take or release request.
interface msa_req_if;
  import msa_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [POS_W-1:0]  position;
  modport source (output valid, mode, position, input ready);
  modport sink   (input valid, mode, position, output ready);
endinterface

// Response channel: one word per request.
interface msa_rsp_if;
  import msa_pkg::*;
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  seat_index;
  logic [STAT_W-1:0] status;
  modport source (output valid, seat_index, status, input ready);
  modport sink   (input valid, seat_index, status, output ready);
endinterface

`default_nettype wire

### rtl/msa_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module msa_datapath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [msa_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  wire logic [msa_pkg::MODE_W-1:0]  in_mode_i,
  input  wire logic [msa_pkg::POS_W-1:0]   in_position_i,
  input  wire logic                        out_ready_i,
  input  wire msa_pkg::ctrl_cmd_t          cmd_i,
  output msa_pkg::dp_sts_t                 sts_o,
  output logic                             out_valid_o,
  output logic [msa_pkg::POS_W-1:0]        out_seat_index_o,
  output logic [msa_pkg::STAT_W-1:0]       out_status_o
);
  import msa_pkg::*;

  // Occupancy map, one bit per seat.
  logic              occ_mem [MAX_SEATS];
  logic              rdata_q;
  logic              rd_en;
  logic [SEAT_W-1:0] rd_addr;
  logic              wr_en;
  logic [SEAT_W-1:0] wr_addr;
  logic              wr_data;

  logic [CFG_W-1:0]  seat_count_q;
  logic [CNT_W-1:0]  eff_cnt;

  logic [SEAT_W-1:0] clr_addr_q;

  mode_e             mode_q;
  logic [POS_W-1:0]  pos_q;

  // Scan state.
  logic [SEAT_W-1:0] addr_q;
  logic              pend_q;
  logic [SEAT_W-1:0] ridx_q;
  logic              any_q, any_d;
  logic [CNT_W-1:0]  taken_q, taken_d;
  logic [SEAT_W-1:0] prev_q, prev_d;
  logic [SEAT_W-1:0] best_q, best_d;
  logic [SEAT_W-1:0] cand_q, cand_d;
  logic [SEAT_W-1:0] gap_half;

  // Finishing step.
  logic [CNT_W-1:0]  tail_gap;
  logic [SEAT_W-1:0] take_pos;
  logic              room_full;
  logic              rel_hit;
  logic              out_valid_q;
  logic [POS_W-1:0]  out_index_q;
  status_e           out_status_q;

  // Seat count register and its clamped value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seat_count_q <= CFG_W'(SEAT_RESET);
    end else if (cfg_we_i) begin
      seat_count_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (seat_count_q == '0) begin
      eff_cnt = CNT_W'(1);
    end else if (32'(seat_count_q) > MAX_SEATS) begin
      eff_cnt = CNT_W'(MAX_SEATS);
    end else begin
      eff_cnt = CNT_W'(seat_count_q);
    end
  end

  // Clearing sweep address after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr_en) begin
      clr_addr_q <= clr_addr_q + SEAT_W'(1);
    end
  end

  // Request word capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q <= mode_e'(in_mode_i);
      pos_q  <= in_position_i;
    end
  end

  // Memory port selection.
  assign rd_en   = cmd_i.scan_rd || (cmd_i.accept && (in_mode_i == MODE_RELEASE));
  assign rd_addr = cmd_i.scan_rd ? addr_q : SEAT_W'(in_position_i);

  assign room_full = (taken_q == eff_cnt);
  assign rel_hit   = (32'(pos_q) < 32'(eff_cnt)) && rdata_q;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_addr_q;
    wr_data = 1'b0;
    if (cmd_i.clr_en) begin
      wr_en = 1'b1;
    end else if (cmd_i.finish) begin
      if (mode_q == MODE_TAKE) begin
        wr_en   = !room_full;
        wr_addr = take_pos;
        wr_data = 1'b1;
      end else begin
        wr_en   = rel_hit;
        wr_addr = SEAT_W'(pos_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      occ_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= occ_mem[rd_addr];
    end
  end

  // Scan address and the pipeline tag of the read in flight.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
      pend_q <= 1'b0;
    end else begin
      pend_q <= cmd_i.scan_rd;
      if (cmd_i.accept) begin
        addr_q <= '0;
      end else if (cmd_i.scan_rd) begin
        addr_q <= addr_q + SEAT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_rd) begin
      ridx_q <= addr_q;
    end
  end

  // Gap tracking: each occupied seat closes the gap that began at the last one.
  assign gap_half = SEAT_W'((ridx_q - prev_q) >> 1);

  always_comb begin
    any_d   = any_q;
    taken_d = taken_q;
    prev_d  = prev_q;
    best_d  = best_q;
    cand_d  = cand_q;
    if (pend_q && rdata_q) begin
      any_d   = 1'b1;
      taken_d = taken_q + CNT_W'(1);
      prev_d  = ridx_q;
      if (!any_q) begin
        best_d = ridx_q;
        cand_d = '0;
      end else if (gap_half > best_q) begin
        best_d = gap_half;
        cand_d = prev_q + gap_half;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_q   <= 1'b0;
      taken_q <= '0;
      prev_q  <= '0;
      best_q  <= '0;
      cand_q  <= '0;
    end else if (cmd_i.accept) begin
      any_q   <= 1'b0;
      taken_q <= '0;
      prev_q  <= '0;
      best_q  <= '0;
      cand_q  <= '0;
    end else begin
      any_q   <= any_d;
      taken_q <= taken_d;
      prev_q  <= prev_d;
      best_q  <= best_d;
      cand_q  <= cand_d;
    end
  end

  // The end seat wins only when strictly farther than every earlier choice.
  assign tail_gap = eff_cnt - CNT_W'(1) - CNT_W'(prev_q);
  assign take_pos = (any_q && (tail_gap > CNT_W'(best_q))) ?
                    SEAT_W'(eff_cnt - CNT_W'(1)) : cand_q;

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (mode_q == MODE_TAKE) begin
        if (room_full) begin
          out_index_q  <= '0;
          out_status_q <= STAT_FULL;
        end else begin
          out_index_q  <= POS_W'(take_pos);
          out_status_q <= STAT_SEATED;
        end
      end else begin
        out_index_q  <= pos_q;
        out_status_q <= rel_hit ? STAT_RELEASED : STAT_IGNORED;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_seat_index_o = out_index_q;
  assign out_status_o     = out_status_q;

  assign sts_o.clr_last  = (32'(clr_addr_q) == MAX_SEATS - 1);
  assign sts_o.scan_last = (CNT_W'(addr_q) == eff_cnt - CNT_W'(1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // Checks on the scan and the chosen seat.
  `ASSERT_CLK(a_scan_in_row, cmd_i.scan_rd |-> (CNT_W'(addr_q) < eff_cnt),
              "scan read beyond the active row")
  `ASSERT_CLK(a_taken_bound, pend_q |-> (taken_q <= CNT_W'(ridx_q)),
              "occupied count runs ahead of the scan")
  `ASSERT_CLK(a_pick_in_row,
              (cmd_i.finish && (mode_q == MODE_TAKE) && !room_full) |->
              (CNT_W'(take_pos) < eff_cnt),
              "chosen seat outside the active row")

endmodule

`default_nettype wire

### rtl/msa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module msa_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire logic [msa_pkg::MODE_W-1:0] in_mode_i,
  output logic                            in_ready_o,
  input  wire msa_pkg::dp_sts_t           sts_i,
  output msa_pkg::ctrl_cmd_t              cmd_o
);
  import msa_pkg::*;

  state_e state_q, state_d;

  // State register; reset starts the clearing sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = (in_mode_i == MODE_RELEASE) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_TAIL;
        end
      end
      S_TAIL: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // One request at a time: no new word until the current one is finished.
  `ASSERT_CLK(a_one_in_flight, cmd_o.accept |=> !in_ready_o,
              "request taken while another is in progress")
  `ASSERT_CLK(a_finish_frees, cmd_o.finish |=> in_ready_o,
              "controller not ready after finishing a request")
  `ASSERT_NEVER(a_accept_alone,
                cmd_o.accept && (cmd_o.scan_rd || cmd_o.finish || cmd_o.clr_en),
                "accept issued together with another command")

endmodule

`default_nettype wire

### rtl/max_distance_seat_allocator_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Word                      Handshake
// req_i     in         mode, position            valid / ready
// rsp_o     out        seat_index, status        valid / ready
// cfg       in         seat_count (11 bits)      cfg_we_i, no wait
//
// A take request scans every active seat: the occupancy memory, which has one read
// port and one write port, is read one seat per cycle during the scan.
// A release request needs one memory read, then the update.
// After reset the block clears the 1024-entry map before it takes the first
// request; configuration writes are accepted during the sweep.
// A stalled response holds in the output register; the next request is taken
// meanwhile and waits at its final step until the register frees up.
module max_distance_seat_allocator_unit (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  msa_req_if.sink                        req_i,
  msa_rsp_if.source                      rsp_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [msa_pkg::CFG_W-1:0] cfg_wdata_i
);
  import msa_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // Sequencer.
  msa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_mode_i  (req_i.mode),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Occupancy map, gap scan and output register.
  msa_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_mode_i        (req_i.mode),
    .in_position_i    (req_i.position),
    .out_ready_i      (rsp_o.ready),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (rsp_o.valid),
    .out_seat_index_o (rsp_o.seat_index),
    .out_status_o     (rsp_o.status)
  );

endmodule

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import msa_pkg::*;

  // Longest stretch without any accepted word before the run is declared hung.
  localparam int STALL_LIMIT = 20000;
  localparam int N_PHASES    = 20;
  localparam int N_DIRECTED  = 25;

  typedef struct packed {
    logic [POS_W-1:0] seat;
    status_e          status;
  } seat_reply_t;

  // A directed step either writes seat_count or sends one request word.
  typedef enum logic [1:0] {
    STEP_CFG,
    STEP_PREDICT,
    STEP_KNOWN
  } step_kind_e;

  typedef struct packed {
    step_kind_e       kind;
    mode_e            mode;
    logic [CFG_W-1:0] arg;
    logic [POS_W-1:0] want_seat;
    status_e          want_status;
  } dir_step_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  msa_req_if req_ch ();
  msa_rsp_if rsp_ch ();

  max_distance_seat_allocator_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the row and of the seat_count register.
  bit               seat_taken [MAX_SEATS];
  logic [CFG_W-1:0] seat_cfg = CFG_W'(SEAT_RESET);
  seat_reply_t      pending_replies [$];
  bit               failed = 1'b0;
  int               quiet_cycles = 0;
  int               send_idle_pct = 22;
  int               recv_idle_pct = 84;

  // The directed steps start from the reset count of 1024 seats.
  dir_step_t directed_steps [N_DIRECTED] = '{
    '{STEP_KNOWN,   MODE_TAKE,    11'd0,    10'd0,    STAT_SEATED},
    '{STEP_KNOWN,   MODE_TAKE,    11'd0,    10'd1023, STAT_SEATED},
    '{STEP_KNOWN,   MODE_TAKE,    11'd1023, 10'd511,  STAT_SEATED},
    '{STEP_KNOWN,   MODE_RELEASE, 11'd1023, 10'd1023, STAT_RELEASED},
    '{STEP_KNOWN,   MODE_RELEASE, 11'd1023, 10'd1023, STAT_IGNORED},
    '{STEP_KNOWN,   MODE_RELEASE, 11'd1000, 10'd1000, STAT_IGNORED},
    '{STEP_KNOWN,   MODE_TAKE,    11'd0,    10'd1023, STAT_SEATED},
    '{STEP_KNOWN,   MODE_RELEASE, 11'd0,    10'd0,    STAT_RELEASED},
    '{STEP_KNOWN,   MODE_TAKE,    11'd0,    10'd0,    STAT_SEATED},
    // A count of zero behaves as a single seat.
    '{STEP_CFG,     MODE_TAKE,    11'd0,    10'd0,    STAT_SEATED},
    '{STEP_KNOWN,   MODE_TAKE,    11'd0,    10'd0,    STAT_FULL},
    '{STEP_KNOWN,   MODE_RELEASE, 11'd5,    10'd5,    STAT_IGNORED},
    '{STEP_KNOWN,   MODE_RELEASE, 11'd511,  10'd511,  STAT_IGNORED},
    '{STEP_KNOWN,   MODE_RELEASE, 11'd0,    10'd0,    STAT_RELEASED},
    '{STEP_KNOWN,   MODE_TAKE,    11'd0,    10'd0,    STAT_SEATED},
    '{STEP_KNOWN,   MODE_TAKE,    11'd0,    10'd0,    STAT_FULL},
    '{STEP_CFG,     MODE_TAKE,    11'd2,    10'd0,    STAT_SEATED},
    '{STEP_KNOWN,   MODE_TAKE,    11'd0,    10'd1,    STAT_SEATED},
    '{STEP_KNOWN,   MODE_TAKE,    11'd0,    10'd0,    STAT_FULL},
    '{STEP_KNOWN,   MODE_RELEASE, 11'd0,    10'd0,    STAT_RELEASED},
    '{STEP_KNOWN,   MODE_TAKE,    11'd0,    10'd0,    STAT_SEATED},
    // An oversized count is clipped to the full row.
    '{STEP_CFG,     MODE_TAKE,    11'd2047, 10'd0,    STAT_SEATED},
    '{STEP_PREDICT, MODE_TAKE,    11'd0,    10'd0,    STAT_SEATED},
    '{STEP_PREDICT, MODE_RELEASE, 11'd1023, 10'd0,    STAT_SEATED},
    '{STEP_PREDICT, MODE_TAKE,    11'd682,  10'd0,    STAT_SEATED}
  };

  function automatic int active_seat_span();
    int span;
    span = int'(seat_cfg);
    if (span == 0) span = 1;
    if (span > MAX_SEATS) span = MAX_SEATS;
    return span;
  endfunction

  // Applies one request to the shadow row and returns the reply it must produce.
  function automatic seat_reply_t serve_request(mode_e m, logic [POS_W-1:0] p);
    int          span;
    int          n_taken;
    int          last_taken;
    int          best_gap;
    int          pick;
    int          mid;
    seat_reply_t r;
    span       = active_seat_span();
    n_taken    = 0;
    last_taken = -1;
    best_gap   = 0;
    pick       = 0;
    if (m == MODE_RELEASE) begin
      r.seat   = p;
      r.status = STAT_IGNORED;
      if (int'(p) < span && seat_taken[p]) begin
        seat_taken[p] = 1'b0;
        r.status      = STAT_RELEASED;
      end
      return r;
    end
    // The lead gap counts its full width, an inner gap its midpoint distance.
    for (int i = 0; i < span; i++) begin
      if (seat_taken[i]) begin
        n_taken++;
        if (last_taken < 0) begin
          best_gap = i;
          pick     = 0;
        end else begin
          mid = last_taken + (i - last_taken) / 2;
          if (mid - last_taken > best_gap) begin
            best_gap = mid - last_taken;
            pick     = mid;
          end
        end
        last_taken = i;
      end
    end
    if (n_taken == span) begin
      r.seat   = '0;
      r.status = STAT_FULL;
      return r;
    end
    // The last seat wins only when strictly farther than every earlier choice.
    if (last_taken >= 0 && span - 1 - last_taken > best_gap) pick = span - 1;
    seat_taken[pick] = 1'b1;
    r.seat   = pick[POS_W-1:0];
    r.status = STAT_SEATED;
    return r;
  endfunction

  // Returns a random occupied seat inside the active span, or -1 if none.
  function automatic int pick_held_seat();
    int held [$];
    for (int i = 0; i < active_seat_span(); i++) begin
      if (seat_taken[i]) held.insert(held.size(), i);
    end
    if (held.size() == 0) return -1;
    return held[$urandom_range(0, held.size() - 1)];
  endfunction

  // Offers one request word and records its reply once the word is taken.
  task automatic offer_request(input mode_e m, input logic [POS_W-1:0] p,
                               input bit known, input seat_reply_t want);
    seat_reply_t predicted;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    req_ch.valid    <= 1'b1;
    req_ch.mode     <= m;
    req_ch.position <= p;
    do @(posedge clk_i); while (!req_ch.ready);
    predicted = serve_request(m, p);
    pending_replies.insert(pending_replies.size(), known ? want : predicted);
  endtask

  // Holds the request channel idle until every reply is back, then settles.
  task automatic wait_for_replies(input int settle);
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_replies.size() != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic set_seat_count(input logic [CFG_W-1:0] value);
    wait_for_replies(8);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    seat_cfg = value;
  endtask

  // Reply side: random back-pressure and comparison against the oldest expectation.
  always @(posedge clk_i) begin
    seat_reply_t want;
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_replies.size() == 0) begin
          $display("%0t: unexpected reply word seat_index %0d status %0d", $time,
                   rsp_ch.seat_index, rsp_ch.status);
          failed = 1'b1;
        end else begin
          want = pending_replies.pop_front();
          if (rsp_ch.seat_index !== want.seat) begin
            $display("%0t: seat_index expected %0d, got %0d", $time, want.seat,
                     rsp_ch.seat_index);
            failed = 1'b1;
          end
          if (rsp_ch.status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status,
                     rsp_ch.status);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a word.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("max_distance_seat_allocator_unit: mismatch");
    $finish;
  end

  initial begin
    int          n_items;
    int          held;
    int          roll;
    seat_reply_t typed;
    logic [CFG_W-1:0] phase_count;
    req_ch.valid    = 1'b0;
    req_ch.mode     = MODE_TAKE;
    req_ch.position = '0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed steps.
    foreach (directed_steps[k]) begin
      typed.seat   = directed_steps[k].want_seat;
      typed.status = directed_steps[k].want_status;
      case (directed_steps[k].kind)
        STEP_CFG: begin
          set_seat_count(directed_steps[k].arg);
        end
        default: begin
          offer_request(directed_steps[k].mode, directed_steps[k].arg[POS_W-1:0],
                        directed_steps[k].kind == STEP_KNOWN, typed);
        end
      endcase
    end

    // Random phases, each with its own seat count; full-row counts stay rare.
    for (int phase = 0; phase < N_PHASES; phase++) begin
      if (phase == 7) begin
        send_idle_pct = 84;
        recv_idle_pct = 22;
      end else if (phase == 14) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (phase)
        3:       phase_count = 11'd0;
        7:       phase_count = 11'd1024;
        12:      phase_count = 11'd2047;
        16:      phase_count = CFG_W'($urandom_range(1025, 2046));
        default: phase_count = CFG_W'($urandom_range(1, 48));
      endcase
      set_seat_count(phase_count);
      n_items = (phase_count > 11'd48) ? 12 : 32;
      for (int k = 0; k < n_items; k++) begin
        // Let the block drain completely now and then.
        if (k == 14) wait_for_replies(0);
        roll = $urandom_range(0, 99);
        held = pick_held_seat();
        if (roll < 55 || (roll < 85 && held < 0)) begin
          offer_request(MODE_TAKE, POS_W'($urandom_range(0, 1023)), 1'b0, typed);
        end else if (roll < 85) begin
          offer_request(MODE_RELEASE, POS_W'(held), 1'b0, typed);
        end else begin
          offer_request(MODE_RELEASE, POS_W'($urandom_range(0, 1023)), 1'b0, typed);
        end
      end
    end

    // Drain, then leave room for a stray reply from a full-row scan.
    wait_for_replies(1100);
    if (!failed) begin
      $display("max_distance_seat_allocator_unit: match");
    end else begin
      $display("max_distance_seat_allocator_unit: mismatch");
    end
    $finish;
  end

endmodule
